// ===== design/camproj_pkg.sv =====
// ----------------------------------------------------------------------------
// camproj_pkg
// Shared widths, register indexes, reset values and fixed-point helpers for
// the camera point projection pipeline. Internal values are signed Q.24.
// ----------------------------------------------------------------------------
package camproj_pkg;

	// fixed-point format
	localparam int Q_W    = 61;   // signed Q.24, saturated to +-(2^60 - 1)
	localparam int FRAC   = 24;
	localparam int MAG_W  = 60;   // magnitude bits of a Q_W value
	localparam int HALF_W = 30;   // partial product split

	// geometry of the front end
	localparam int PT_W   = 21;
	localparam int COEF_W = 18;
	localparam int K_W    = 20;
	localparam int CAM_W  = 41;   // camera-space sum of three products plus offset

	// reciprocal 2^48 / |z|
	localparam int QUO_W     = 49;
	localparam int RECIP_LAT = QUO_W + 2;
	localparam int FMUL_LAT  = 3;

	// output
	localparam int PIX_W  = 10;
	localparam int PIXI_W = 36;   // integer bits of a nonnegative Q.24 value

	// configuration port
	localparam int CFG_W = 63;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_ROT0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROT1 = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROT2 = 3'd2;
	localparam logic [IDX_W-1:0] REG_TRAN = 3'd3;
	localparam logic [IDX_W-1:0] REG_XINT = 3'd4;
	localparam logic [IDX_W-1:0] REG_YINT = 3'd5;
	localparam logic [IDX_W-1:0] REG_RAD  = 3'd6;
	localparam logic [IDX_W-1:0] REG_TAN  = 3'd7;

	// register reset values: identity rotation, focal 1.0, all else zero
	localparam logic [53:0] ROT0_RST = 54'd65536;
	localparam logic [53:0] ROT1_RST = 54'd17179869184;
	localparam logic [53:0] ROT2_RST = 54'd4503599627370496;
	localparam logic [43:0] INTR_RST = 44'd256;

	localparam int IMG_ROWS_DEF = 1024;
	localparam int IMG_COLS_DEF = 1024;

	localparam logic signed [63:0] LIM64 = 64'sh0FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] ONE64 = 64'sh0000_0000_0100_0000;
	localparam logic signed [Q_W-1:0] ONE_Q = 61'sh100_0000;

	// sign-extend a Q.24 value for summing
	function automatic logic signed [63:0] ext64(input logic signed [Q_W-1:0] v);
		return 64'(v);
	endfunction

	// saturate a sum to the Q.24 range
	function automatic logic signed [Q_W-1:0] sat(input logic signed [63:0] v);
		logic signed [Q_W-1:0] r;
		if (v > LIM64)
			r = Q_W'(LIM64);
		else if (v < -LIM64)
			r = Q_W'(-LIM64);
		else
			r = v[Q_W-1:0];
		return r;
	endfunction

	// signed Q4.16 coefficient to Q.24
	function automatic logic signed [Q_W-1:0] coef_q24(input logic [K_W-1:0] k);
		return $signed({{(Q_W-K_W-8){k[K_W-1]}}, k, 8'b0});
	endfunction

	// truncate toward zero and clamp to [0, lim]
	function automatic logic [PIX_W-1:0] to_pix(input logic signed [Q_W-1:0] p,
			input logic [PIXI_W-1:0] lim);
		logic [PIXI_W-1:0] i;
		i = p[FRAC+PIXI_W-1:FRAC];
		if (p < 0)
			i = '0;
		else if (i > lim)
			i = lim;
		return i[PIX_W-1:0];
	endfunction

endpackage

// ===== design/camproj_delay.sv =====
// ----------------------------------------------------------------------------
// camproj_delay
// Fixed-length register delay line that keeps operands aligned between
// pipeline branches of different depth.
// ----------------------------------------------------------------------------
module camproj_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_q [N];

	// shift one place per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++)
				pipe_q[i] <= '0;
		end else begin
			pipe_q[0] <= d;
			for (int i = 1; i < N; i++)
				pipe_q[i] <= pipe_q[i-1];
		end
	end

	assign q = pipe_q[N-1];

endmodule

// ===== design/camproj_fmul.sv =====
// ----------------------------------------------------------------------------
// camproj_fmul
// Three-stage Q.24 multiplier: magnitude, four 30x30 partial products,
// then recombination with truncation toward zero and saturation.
// ----------------------------------------------------------------------------
module camproj_fmul (
	input  logic                                clk,
	input  logic signed [camproj_pkg::Q_W-1:0]  a,
	input  logic signed [camproj_pkg::Q_W-1:0]  b,
	output logic signed [camproj_pkg::Q_W-1:0]  y
);

	localparam int QW = camproj_pkg::Q_W;
	localparam int MW = camproj_pkg::MAG_W;
	localparam int HW = camproj_pkg::HALF_W;
	localparam int PW = 2 * HW;
	localparam int FW = 2 * MW;
	localparam int RW = FW - camproj_pkg::FRAC;

	logic          neg_s1, neg_s2;
	logic [MW-1:0] ma_s1, mb_s1;
	logic [PW-1:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic [FW-1:0] full;
	logic [RW-1:0] trunc;
	logic [MW-1:0] mag;

	// stage 1: sign and magnitudes
	always_ff @(posedge clk) begin
		neg_s1 <= a[QW-1] ^ b[QW-1];
		ma_s1  <= a[QW-1] ? MW'(-a) : MW'(a);
		mb_s1  <= b[QW-1] ? MW'(-b) : MW'(b);
	end

	// stage 2: partial products
	always_ff @(posedge clk) begin
		neg_s2 <= neg_s1;
		p00_s2 <= PW'(ma_s1[HW-1:0])  * PW'(mb_s1[HW-1:0]);
		p01_s2 <= PW'(ma_s1[HW-1:0])  * PW'(mb_s1[MW-1:HW]);
		p10_s2 <= PW'(ma_s1[MW-1:HW]) * PW'(mb_s1[HW-1:0]);
		p11_s2 <= PW'(ma_s1[MW-1:HW]) * PW'(mb_s1[MW-1:HW]);
	end

	// recombine, drop fraction bits, saturate
	always_comb begin
		full  = (FW'(p11_s2) << PW) + ((FW'(p01_s2) + FW'(p10_s2)) << HW) + FW'(p00_s2);
		trunc = full[FW-1:camproj_pkg::FRAC];
		mag   = (trunc[RW-1:MW] != '0) ? {MW{1'b1}} : trunc[MW-1:0];
	end

	// stage 3: apply sign
	always_ff @(posedge clk) begin
		y <= neg_s2 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

endmodule

// ===== design/camproj_recip.sv =====
// ----------------------------------------------------------------------------
// camproj_recip
// Pipelined restoring divider for 2^48 / |z|, one quotient bit per stage,
// with the sign of z restored and a scale of one when z is zero.
// ----------------------------------------------------------------------------
module camproj_recip (
	input  logic                                clk,
	input  logic signed [camproj_pkg::CAM_W-1:0] z,
	output logic signed [camproj_pkg::Q_W-1:0]   recip
);

	localparam int CW = camproj_pkg::CAM_W;
	localparam int NQ = camproj_pkg::QUO_W;
	localparam int QW = camproj_pkg::Q_W;

	logic [CW-1:0] mz_s   [NQ+1];
	logic [CW-1:0] rem_s  [NQ+1];
	logic [NQ-1:0] quo_s  [NQ+1];
	logic          neg_s  [NQ+1];
	logic          zero_s [NQ+1];

	// entry stage: magnitude and flags
	always_ff @(posedge clk) begin
		mz_s[0]   <= z[CW-1] ? CW'(-z) : CW'(z);
		neg_s[0]  <= z[CW-1];
		zero_s[0] <= (z == '0);
		rem_s[0]  <= '0;
		quo_s[0]  <= '0;
	end

	// one compare-subtract per stage; dividend is a one followed by zeros
	for (genvar k = 0; k < NQ; k++) begin : g_step
		logic [CW:0] shifted;
		logic        ge;

		always_comb begin
			shifted = {rem_s[k], 1'(k == 0)};
			ge      = shifted >= {1'b0, mz_s[k]};
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? CW'(shifted - {1'b0, mz_s[k]}) : shifted[CW-1:0];
			quo_s[k+1]  <= {quo_s[k][NQ-2:0], ge};
			mz_s[k+1]   <= mz_s[k];
			neg_s[k+1]  <= neg_s[k];
			zero_s[k+1] <= zero_s[k];
		end
	end

	// output stage: sign and zero-depth override
	always_ff @(posedge clk) begin
		if (zero_s[NQ])
			recip <= camproj_pkg::ONE_Q;
		else if (neg_s[NQ])
			recip <= -$signed(QW'(quo_s[NQ]));
		else
			recip <= $signed(QW'(quo_s[NQ]));
	end

endmodule

// ===== design/camera_point_projection.sv =====
// ----------------------------------------------------------------------------
// camera_point_projection
// Pinhole projection of 3D points with radial and tangential lens
// distortion, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with point_x/y/z (signed Q13.8). busy is always low, so a
//   point is transferred on every clock edge at which start is high; a new
//   point may follow every cycle.
//   Each point yields one transfer on done, pixel_row and pixel_col after its
//   start transfer, in input order. A point passes through the three
//   front-end stages, the reciprocal divider (49 quotient stages), seven
//   chained three-stage Q.24 multipliers and four adder stages.
//   Throughput is one point per cycle. done is high for one cycle per result;
//   the receiver must take it then, as there is no backpressure.
//   Camera registers are written through cfg_we/cfg_index/cfg_wdata, taking
//   effect at once; write them only while no point is in flight.
//   Reset clears all in-flight points and loads the identity rotation, zero
//   translation and distortion, focal 1.0 and centre 0.
// ----------------------------------------------------------------------------
module camera_point_projection #(
	parameter int IMG_ROWS = camproj_pkg::IMG_ROWS_DEF,
	parameter int IMG_COLS = camproj_pkg::IMG_COLS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [camproj_pkg::PT_W-1:0]    point_x,
	input  logic signed [camproj_pkg::PT_W-1:0]    point_y,
	input  logic signed [camproj_pkg::PT_W-1:0]    point_z,
	input  logic                                   cfg_we,
	input  logic [camproj_pkg::IDX_W-1:0]          cfg_index,
	input  logic [camproj_pkg::CFG_W-1:0]          cfg_wdata,
	output logic                                   done,
	output logic [camproj_pkg::PIX_W-1:0]          pixel_row,
	output logic [camproj_pkg::PIX_W-1:0]          pixel_col
);

	localparam int QW  = camproj_pkg::Q_W;
	localparam int CW  = camproj_pkg::CAM_W;
	localparam int PTW = camproj_pkg::PT_W;
	localparam int CFW = camproj_pkg::COEF_W;
	localparam int KW  = camproj_pkg::K_W;
	localparam int PRW = CFW + PTW;
	localparam int FL  = camproj_pkg::FMUL_LAT;
	localparam int DL  = camproj_pkg::RECIP_LAT;

	// register-time of each result, counted from the start transfer
	localparam int T_CAM = 3;
	localparam int T_REC = T_CAM + DL;
	localparam int T_N   = T_REC + FL;
	localparam int T_SQ  = T_N + FL;
	localparam int T_S1  = T_SQ + 1;
	localparam int T_S2  = T_S1 + 1;
	localparam int T_R4  = T_S1 + FL;
	localparam int T_R6  = T_R4 + FL;
	localparam int T_K6  = T_R6 + FL;
	localparam int T_CD  = T_K6 + 1;
	localparam int T_XC  = T_CD + FL;
	localparam int T_D   = T_XC + 1;
	localparam int T_F   = T_D + FL;
	localparam int T_OUT = T_F + 1;

	localparam logic [camproj_pkg::PIXI_W-1:0] ROW_MAX = camproj_pkg::PIXI_W'(IMG_ROWS - 1);
	localparam logic [camproj_pkg::PIXI_W-1:0] COL_MAX = camproj_pkg::PIXI_W'(IMG_COLS - 1);

	// configuration registers
	logic [53:0] rot_q [3];
	logic [62:0] tran_q;
	logic [43:0] xint_q, yint_q;
	logic [59:0] rad_q;
	logic [39:0] tan_q;

	// front end
	logic                  v_s1;
	logic signed [PTW-1:0] pt_s1   [3];
	logic signed [PRW-1:0] prod_s2 [3][3];
	logic signed [CW-1:0]  cam_s3  [3];
	logic signed [CW-1:0]  camx_d, camy_d;

	// Q.24 datapath
	logic signed [QW-1:0] recip, xn, yn, xx, yy, xy;
	logic signed [QW-1:0] r2_s4, a1_s4, xx_s4, yy_s4, a2_s5, a3_s5;
	logic signed [QW-1:0] r4, kr2, r2_d, r6, kr4, kr6, kr2_d, kr4_d, cd_s6;
	logic signed [QW-1:0] p1a1, p2a1, p2a2, p1a3, p1a1_d, p2a1_d, p2a2_d, p1a3_d;
	logic signed [QW-1:0] xn_d, yn_d, xcd, ycd, xd_s7, yd_s7, fx_p, fy_p;
	logic signed [QW-1:0] k0, k1, k4, p1, p2, fx, fy;
	logic signed [63:0]   cx, cy;
	logic                 v_out;

	assign busy = 1'b0;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= camproj_pkg::ROT0_RST;
			rot_q[1] <= camproj_pkg::ROT1_RST;
			rot_q[2] <= camproj_pkg::ROT2_RST;
			tran_q   <= '0;
			xint_q   <= camproj_pkg::INTR_RST;
			yint_q   <= camproj_pkg::INTR_RST;
			rad_q    <= '0;
			tan_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				camproj_pkg::REG_ROT0: rot_q[0] <= cfg_wdata[53:0];
				camproj_pkg::REG_ROT1: rot_q[1] <= cfg_wdata[53:0];
				camproj_pkg::REG_ROT2: rot_q[2] <= cfg_wdata[53:0];
				camproj_pkg::REG_TRAN: tran_q   <= cfg_wdata[62:0];
				camproj_pkg::REG_XINT: xint_q   <= cfg_wdata[43:0];
				camproj_pkg::REG_YINT: yint_q   <= cfg_wdata[43:0];
				camproj_pkg::REG_RAD:  rad_q    <= cfg_wdata[59:0];
				camproj_pkg::REG_TAN:  tan_q    <= cfg_wdata[39:0];
				default: ;
			endcase
		end
	end

	// coefficients in Q.24
	assign k0 = camproj_pkg::coef_q24(rad_q[KW-1:0]);
	assign k1 = camproj_pkg::coef_q24(rad_q[2*KW-1:KW]);
	assign k4 = camproj_pkg::coef_q24(rad_q[3*KW-1:2*KW]);
	assign p1 = camproj_pkg::coef_q24(tan_q[KW-1:0]);
	assign p2 = camproj_pkg::coef_q24(tan_q[2*KW-1:KW]);
	assign fx = $signed({{(QW-40){1'b0}}, xint_q[23:0], 16'b0});
	assign fy = $signed({{(QW-40){1'b0}}, yint_q[23:0], 16'b0});
	assign cx = $signed({{28{1'b0}}, xint_q[43:24], 16'b0});
	assign cy = $signed({{28{1'b0}}, yint_q[43:24], 16'b0});

	// stage 1: input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		pt_s1[0] <= point_x;
		pt_s1[1] <= point_y;
		pt_s1[2] <= point_z;
	end

	// stage 2: rotation products
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				prod_s2[r][c] <= $signed(rot_q[r][CFW*c +: CFW]) * pt_s1[c];
	end

	// stage 3: camera-space sums with translation
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++)
			cam_s3[r] <= CW'(prod_s2[r][0]) + CW'(prod_s2[r][1]) + CW'(prod_s2[r][2])
				+ CW'($signed({tran_q[PTW*r +: PTW], 16'b0}));
	end

	// depth reciprocal, x and y held alongside
	camproj_recip u_recip (.clk(clk), .z(cam_s3[2]), .recip(recip));

	camproj_delay #(.W(CW), .N(DL)) u_dcamx (
		.clk(clk), .arst_n(arst_n), .d(cam_s3[0]), .q(camx_d));
	camproj_delay #(.W(CW), .N(DL)) u_dcamy (
		.clk(clk), .arst_n(arst_n), .d(cam_s3[1]), .q(camy_d));

	// normalized coordinates
	camproj_fmul u_xn (.clk(clk), .a(QW'(camx_d)), .b(recip), .y(xn));
	camproj_fmul u_yn (.clk(clk), .a(QW'(camy_d)), .b(recip), .y(yn));

	// squares and cross term
	camproj_fmul u_xx (.clk(clk), .a(xn), .b(xn), .y(xx));
	camproj_fmul u_yy (.clk(clk), .a(yn), .b(yn), .y(yy));
	camproj_fmul u_xy (.clk(clk), .a(xn), .b(yn), .y(xy));

	// stage 4: r^2 and tangential term 2xy
	always_ff @(posedge clk) begin
		r2_s4 <= camproj_pkg::sat(camproj_pkg::ext64(xx) + camproj_pkg::ext64(yy));
		a1_s4 <= camproj_pkg::sat(camproj_pkg::ext64(xy) + camproj_pkg::ext64(xy));
		xx_s4 <= xx;
		yy_s4 <= yy;
	end

	// stage 5: r^2 + 2x^2 and r^2 + 2y^2
	always_ff @(posedge clk) begin
		a2_s5 <= camproj_pkg::sat(camproj_pkg::ext64(r2_s4) + camproj_pkg::ext64(xx_s4)
			+ camproj_pkg::ext64(xx_s4));
		a3_s5 <= camproj_pkg::sat(camproj_pkg::ext64(r2_s4) + camproj_pkg::ext64(yy_s4)
			+ camproj_pkg::ext64(yy_s4));
	end

	// radial powers and terms
	camproj_fmul u_r4  (.clk(clk), .a(r2_s4), .b(r2_s4), .y(r4));
	camproj_fmul u_kr2 (.clk(clk), .a(k0),    .b(r2_s4), .y(kr2));

	camproj_delay #(.W(QW), .N(T_R4 - T_S1)) u_dr2 (
		.clk(clk), .arst_n(arst_n), .d(r2_s4), .q(r2_d));

	camproj_fmul u_r6  (.clk(clk), .a(r4), .b(r2_d), .y(r6));
	camproj_fmul u_kr4 (.clk(clk), .a(k1), .b(r4),   .y(kr4));
	camproj_fmul u_kr6 (.clk(clk), .a(k4), .b(r6),   .y(kr6));

	camproj_delay #(.W(QW), .N(T_K6 - T_R4)) u_dkr2 (
		.clk(clk), .arst_n(arst_n), .d(kr2), .q(kr2_d));
	camproj_delay #(.W(QW), .N(T_K6 - T_R6)) u_dkr4 (
		.clk(clk), .arst_n(arst_n), .d(kr4), .q(kr4_d));

	// stage 6: radial scale
	always_ff @(posedge clk) begin
		cd_s6 <= camproj_pkg::sat(camproj_pkg::ONE64 + camproj_pkg::ext64(kr2_d)
			+ camproj_pkg::ext64(kr4_d) + camproj_pkg::ext64(kr6));
	end

	// tangential products
	camproj_fmul u_p1a1 (.clk(clk), .a(p1), .b(a1_s4), .y(p1a1));
	camproj_fmul u_p2a1 (.clk(clk), .a(p2), .b(a1_s4), .y(p2a1));
	camproj_fmul u_p2a2 (.clk(clk), .a(p2), .b(a2_s5), .y(p2a2));
	camproj_fmul u_p1a3 (.clk(clk), .a(p1), .b(a3_s5), .y(p1a3));

	camproj_delay #(.W(QW), .N(T_XC - T_S1 - FL)) u_dp1a1 (
		.clk(clk), .arst_n(arst_n), .d(p1a1), .q(p1a1_d));
	camproj_delay #(.W(QW), .N(T_XC - T_S1 - FL)) u_dp2a1 (
		.clk(clk), .arst_n(arst_n), .d(p2a1), .q(p2a1_d));
	camproj_delay #(.W(QW), .N(T_XC - T_S2 - FL)) u_dp2a2 (
		.clk(clk), .arst_n(arst_n), .d(p2a2), .q(p2a2_d));
	camproj_delay #(.W(QW), .N(T_XC - T_S2 - FL)) u_dp1a3 (
		.clk(clk), .arst_n(arst_n), .d(p1a3), .q(p1a3_d));

	// radial scaling of the normalized point
	camproj_delay #(.W(QW), .N(T_CD - T_N)) u_dxn (
		.clk(clk), .arst_n(arst_n), .d(xn), .q(xn_d));
	camproj_delay #(.W(QW), .N(T_CD - T_N)) u_dyn (
		.clk(clk), .arst_n(arst_n), .d(yn), .q(yn_d));

	camproj_fmul u_xcd (.clk(clk), .a(xn_d), .b(cd_s6), .y(xcd));
	camproj_fmul u_ycd (.clk(clk), .a(yn_d), .b(cd_s6), .y(ycd));

	// stage 7: distorted coordinates
	always_ff @(posedge clk) begin
		xd_s7 <= camproj_pkg::sat(camproj_pkg::ext64(xcd) + camproj_pkg::ext64(p1a1_d)
			+ camproj_pkg::ext64(p2a2_d));
		yd_s7 <= camproj_pkg::sat(camproj_pkg::ext64(ycd) + camproj_pkg::ext64(p1a3_d)
			+ camproj_pkg::ext64(p2a1_d));
	end

	// focal scaling
	camproj_fmul u_fx (.clk(clk), .a(xd_s7), .b(fx), .y(fx_p));
	camproj_fmul u_fy (.clk(clk), .a(yd_s7), .b(fy), .y(fy_p));

	// stage 8: centre offset, truncate and clamp
	always_ff @(posedge clk) begin
		pixel_col <= camproj_pkg::to_pix(camproj_pkg::sat(camproj_pkg::ext64(fx_p) + cx),
			COL_MAX);
		pixel_row <= camproj_pkg::to_pix(camproj_pkg::sat(camproj_pkg::ext64(fy_p) + cy),
			ROW_MAX);
	end

	// valid follows the data through the whole pipeline
	camproj_delay #(.W(1), .N(T_OUT - 1)) u_dvalid (
		.clk(clk), .arst_n(arst_n), .d(v_s1), .q(v_out));

	assign done = v_out;

endmodule
